FILE: sv/load_cell_adc_reader_top_defines.svh
// ----------------------------------------------------------------------------
// load_cell_adc_reader_top_defines
// Assertion macros shared by the load cell reader modules. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_ADC_READER_TOP_DEFINES_SVH
`define LOAD_CELL_ADC_READER_TOP_DEFINES_SVH

// Condition must never hold outside reset
`define LCAR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lcar assertion failed: forbidden condition");

// Consequent must hold in the same cycle as the antecedent
`define LCAR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcar assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define LCAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcar assertion failed: next-cycle implication");

`endif

FILE: sv/lcar_pkg.sv
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared types, constants and helper functions of the load cell reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

    // Parameter defaults
    localparam int DATA_BITS_DEF       = 24;
    localparam int RECIP_FRAC_BITS_DEF = 24;

    // Configuration port geometry
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_GAIN_SELECT      = 2'd0;
    localparam logic [1:0] REG_SAMPLE_COUNT     = 2'd1;
    localparam logic [1:0] REG_ZERO_OFFSET      = 2'd2;
    localparam logic [1:0] REG_SCALE_RECIPROCAL = 2'd3;

    // Register reset values
    localparam logic [1:0]  GAIN_SELECT_RST      = 2'd0;
    localparam logic [7:0]  SAMPLE_COUNT_RST     = 8'd10;
    localparam logic [24:0] ZERO_OFFSET_RST      = 25'd0;
    localparam logic [31:0] SCALE_RECIPROCAL_RST = 32'h0100_0000;

    // Gain codes
    localparam logic [1:0] GAIN_A128   = 2'd0;
    localparam logic [1:0] GAIN_A64    = 2'd1;
    localparam logic [1:0] GAIN_B32    = 2'd2;
    localparam logic [1:0] GAIN_UNUSED = 2'd3;

    // Output field widths
    localparam int RAW_W    = 24;
    localparam int NET_W    = 26;
    localparam int WEIGHT_W = 42;
    localparam int SUM_W    = 32;
    localparam int PROD_W   = NET_W + 32;

    // Divider geometry: sum over a count of at most 256
    localparam int DEN_W    = 9;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Commands from controller to datapath
    typedef struct packed {
        logic step;      // apply one tick word
        logic div_iter;  // one restoring divide step
        logic net;       // form average minus offset
        logic mul;       // multiply by the reciprocal
        logic fin;       // scale, saturate and load the result word
    } lcar_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic finish;    // this tick ends the measurement
        logic div_last;  // last divide step in progress
    } lcar_sts_t;

    // Map the unused gain code onto gain 128
    function automatic logic [1:0] norm_gain(input logic [1:0] g);
        logic [1:0] r;
        r = (g == GAIN_UNUSED) ? GAIN_A128 : g;
        return r;
    endfunction

    // Serial clock pulses per conversion for a gain code
    function automatic logic [4:0] pulse_count(input logic [1:0] g);
        logic [4:0] r;
        case (g)
            GAIN_A128: r = 5'd25;
            GAIN_A64:  r = 5'd27;
            GAIN_B32:  r = 5'd26;
            default:   r = 5'd25;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/lcar_ctrl.sv
// ----------------------------------------------------------------------------
// lcar_ctrl
// Sequencer: takes one tick word, runs the divide/scale steps when a
// measurement ends, and hands the result word out.
// ----------------------------------------------------------------------------
`include "load_cell_adc_reader_top_defines.svh"

module lcar_ctrl
    import lcar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output lcar_cmd_t cmd,
    input  lcar_sts_t sts
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_DIV,
        C_NET,
        C_MUL,
        C_FIN,
        C_OUT
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        in_ready_reg, in_ready_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;

    assign accept    = in_valid && in_ready_reg;
    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    // Decode commands from state
    always_comb
    begin
        cmd          = '0;
        cmd.step     = accept && (state_reg == C_IDLE);
        cmd.div_iter = (state_reg == C_DIV);
        cmd.net      = (state_reg == C_NET);
        cmd.mul      = (state_reg == C_MUL);
        cmd.fin      = (state_reg == C_FIN);
    end

    // Advance the sequence
    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    in_ready_next = 1'b0;
                    if (sts.finish)
                    begin
                        state_next = C_DIV;
                    end
                    else
                    begin
                        state_next     = C_OUT;
                        out_valid_next = 1'b1;
                    end
                end
            end
            C_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = C_NET;
                end
            end
            C_NET:
            begin
                state_next = C_MUL;
            end
            C_MUL:
            begin
                state_next = C_FIN;
            end
            C_FIN:
            begin
                state_next     = C_OUT;
                out_valid_next = 1'b1;
            end
            C_OUT:
            begin
                if (out_ready)
                begin
                    state_next     = C_IDLE;
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                end
            end
            default:
            begin
                state_next     = C_IDLE;
                out_valid_next = 1'b0;
                in_ready_next  = 1'b1;
            end
        endcase
    end

    // Hold state and handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `LCAR_ASSERT_NEVER(a_ready_and_valid, in_ready_reg && out_valid_reg)
    `LCAR_ASSERT_NEXT(a_accept_drops_ready, accept, !in_ready_reg)
    `LCAR_ASSERT_NEXT(a_div_to_net, (state_reg == C_DIV) && sts.div_last, state_reg == C_NET)

endmodule

FILE: sv/lcar_dp.sv
// ----------------------------------------------------------------------------
// lcar_dp
// Datapath: serial clock phase, bit capture, conversion sum, restoring
// divider, offset subtract, reciprocal multiply and result word register.
// ----------------------------------------------------------------------------
`include "load_cell_adc_reader_top_defines.svh"

module lcar_dp
    import lcar_pkg::*;
#(
    parameter int DATA_BITS       = DATA_BITS_DEF,
    parameter int RECIP_FRAC_BITS = RECIP_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lcar_cmd_t           cmd,
    output lcar_sts_t           sts,
    input  logic                dout_level,
    input  logic                start_request,
    input  logic [1:0]          gain_select,
    input  logic [7:0]          sample_count,
    input  logic [24:0]         zero_offset,
    input  logic [31:0]         scale_reciprocal,
    output logic                sck_level,
    output logic                measure_done,
    output logic [RAW_W-1:0]    raw_average,
    output logic [NET_W-1:0]    net_value,
    output logic [WEIGHT_W-1:0] weight_units,
    output logic                busy_res
);

    localparam int SCALE_SHIFT = RECIP_FRAC_BITS - 8;
    localparam logic [DATA_BITS-1:0] SIGN_MASK = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] WT_HI = (PROD_W'(1) <<< (WEIGHT_W-1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] WT_LO = -(PROD_W'(1) <<< (WEIGHT_W-1));

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [4:0]                 pulse_reg, pulse_next;
    logic [DATA_BITS-1:0]       shift_reg, shift_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [7:0]                 conv_reg, conv_next;
    logic [1:0]                 last_gain_reg, last_gain_next;
    logic                       prime_reg, prime_next;

    logic [SUM_W-1:0]           quot_reg, quot_next;
    logic [DEN_W-1:0]           rem_reg, rem_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;

    logic signed [NET_W-1:0]    net_reg, net_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic                       sck_reg, sck_next;
    logic                       done_reg, done_next;
    logic [RAW_W-1:0]           raw_reg, raw_next;
    logic [NET_W-1:0]           net_out_reg, net_out_next;
    logic [WEIGHT_W-1:0]        wt_reg, wt_next;
    logic                       busy_reg, busy_next;

    logic [DATA_BITS-1:0]       shift_calc;
    logic [DATA_BITS-1:0]       conv_value;
    logic [4:0]                 pulse_inc;
    logic [7:0]                 conv_inc;
    logic [7:0]                 want;
    logic [1:0]                 gain_norm;
    logic                       finish;
    logic                       sck_tick;
    logic [DEN_W:0]             rem_shift;
    logic [DEN_W:0]             rem_diff;
    logic signed [PROD_W-1:0]   prod_shift;
    logic [WEIGHT_W-1:0]        wt_sat;

    // Capture one data bit while fewer than DATA_BITS are taken
    assign shift_calc = (pulse_reg < 5'(DATA_BITS)) ? {shift_reg[DATA_BITS-2:0], dout_level}
                                                    : shift_reg;
    assign conv_value = shift_calc ^ SIGN_MASK;
    assign pulse_inc  = pulse_reg + 5'd1;
    assign conv_inc   = conv_reg + 8'd1;
    assign want       = (sample_count == 8'd0) ? 8'd1 : sample_count;
    assign gain_norm  = norm_gain(gain_select);

    // Restoring divide step
    assign rem_shift  = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_diff   = rem_shift - {1'b0, den_reg};

    // Scale and saturate the product
    assign prod_shift = prod_reg >>> SCALE_SHIFT;
    assign wt_sat     = (prod_shift > WT_HI) ? WT_HI[WEIGHT_W-1:0] :
                        (prod_shift < WT_LO) ? WT_LO[WEIGHT_W-1:0] :
                                               prod_shift[WEIGHT_W-1:0];

    assign sts.finish   = finish;
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(SUM_W-1));

    // Next state of the tick logic and arithmetic steps
    always_comb
    begin
        phase_next     = phase_reg;
        pulse_next     = pulse_reg;
        shift_next     = shift_reg;
        sum_next       = sum_reg;
        conv_next      = conv_reg;
        last_gain_next = last_gain_reg;
        prime_next     = prime_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        div_cnt_next   = div_cnt_reg;
        net_next       = net_reg;
        prod_next      = prod_reg;
        sck_next       = sck_reg;
        done_next      = done_reg;
        raw_next       = raw_reg;
        net_out_next   = net_out_reg;
        wt_next        = wt_reg;
        busy_next      = busy_reg;
        finish         = 1'b0;
        sck_tick       = 1'b0;

        // Apply one tick word
        if (cmd.step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start_request)
                    begin
                        sum_next  = '0;
                        conv_next = '0;
                        if (gain_norm != last_gain_reg)
                        begin
                            last_gain_next = gain_norm;
                            prime_next     = 1'b1;
                        end
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (!dout_level)
                    begin
                        pulse_next = '0;
                        shift_next = '0;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    sck_tick   = 1'b1;
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    shift_next = shift_calc;
                    if (pulse_inc >= pulse_count(last_gain_reg))
                    begin
                        pulse_next = '0;
                        phase_next = PH_WAIT;
                        if (prime_reg)
                        begin
                            prime_next = 1'b0;
                        end
                        else
                        begin
                            sum_next  = sum_reg + SUM_W'(conv_value);
                            conv_next = conv_inc;
                            if ((conv_inc == 8'd0) || (conv_inc >= want))
                            begin
                                finish     = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        pulse_next = pulse_inc;
                        phase_next = PH_HIGH;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            sck_next     = sck_tick;
            busy_next    = (phase_next != PH_IDLE);
            done_next    = 1'b0;
            raw_next     = '0;
            net_out_next = '0;
            wt_next      = '0;

            // Load the divider: a wrapped count of zero means 256
            if (finish)
            begin
                quot_next    = sum_next;
                rem_next     = '0;
                den_next     = {(conv_inc == 8'd0), conv_inc};
                div_cnt_next = '0;
            end
        end

        // One quotient bit per cycle
        if (cmd.div_iter)
        begin
            if (!rem_diff[DEN_W])
            begin
                rem_next  = rem_diff[DEN_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[DEN_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        // Average minus tare offset
        if (cmd.net)
        begin
            net_next = $signed({2'b00, quot_reg[RAW_W-1:0]})
                     - $signed({zero_offset[24], zero_offset});
        end

        // Multiply by the signed reciprocal
        if (cmd.mul)
        begin
            prod_next = PROD_W'(net_reg) * PROD_W'($signed(scale_reciprocal));
        end

        // Load the finished result word
        if (cmd.fin)
        begin
            done_next    = 1'b1;
            raw_next     = quot_reg[RAW_W-1:0];
            net_out_next = net_reg;
            wt_next      = wt_sat;
        end
    end

    // Hold datapath state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pulse_reg     <= '0;
            shift_reg     <= '0;
            sum_reg       <= '0;
            conv_reg      <= '0;
            last_gain_reg <= GAIN_A128;
            prime_reg     <= 1'b0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            div_cnt_reg   <= '0;
            net_reg       <= '0;
            prod_reg      <= '0;
            sck_reg       <= 1'b0;
            done_reg      <= 1'b0;
            raw_reg       <= '0;
            net_out_reg   <= '0;
            wt_reg        <= '0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pulse_reg     <= pulse_next;
            shift_reg     <= shift_next;
            sum_reg       <= sum_next;
            conv_reg      <= conv_next;
            last_gain_reg <= last_gain_next;
            prime_reg     <= prime_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            den_reg       <= den_next;
            div_cnt_reg   <= div_cnt_next;
            net_reg       <= net_next;
            prod_reg      <= prod_next;
            sck_reg       <= sck_next;
            done_reg      <= done_next;
            raw_reg       <= raw_next;
            net_out_reg   <= net_out_next;
            wt_reg        <= wt_next;
            busy_reg      <= busy_next;
        end
    end

    assign sck_level    = sck_reg;
    assign measure_done = done_reg;
    assign raw_average  = raw_reg;
    assign net_value    = net_out_reg;
    assign weight_units = wt_reg;
    assign busy_res     = busy_reg;

    `LCAR_ASSERT_IMPL(a_done_not_busy, done_reg, !busy_reg && !sck_reg)
    `LCAR_ASSERT_IMPL(a_fields_zero, !done_reg, (raw_reg == '0) && (net_out_reg == '0) && (wt_reg == '0))
    `LCAR_ASSERT_NEXT(a_fin_sets_done, cmd.fin, done_reg)

endmodule

FILE: sv/load_cell_adc_reader_top.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader_top
// Load cell converter reader: serial clock driver, conversion averager and
// fixed-point scaler behind a valid/ready tick channel and an APB port.
// ----------------------------------------------------------------------------
// Each input word is one half period of the converter's serial clock and
// yields exactly one result word carrying the clock level to drive, the busy
// flag and, on the last tick of a measurement, the average, the net value and
// the scaled weight. The block works on one word at a time: an ordinary tick
// is accepted, its result word is offered in the very next cycle, and input
// ready returns the cycle after that result is taken. The tick that ends a
// measurement runs the 32-step restoring divider for the average, then the
// offset subtract, the reciprocal multiply and the scaling stage.
// Registers are to be written through the APB port while no word is in
// flight; the block does not enforce it. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_top
    import lcar_pkg::*;
#(
    parameter int DATA_BITS       = DATA_BITS_DEF,
    parameter int RECIP_FRAC_BITS = RECIP_FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Tick word in
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                dout_level,
    input  logic                start_request,
    // Result word out
    output logic                out_valid,
    input  logic                out_ready,
    output logic                sck_level,
    output logic                measure_done,
    output logic [RAW_W-1:0]    raw_average,
    output logic [NET_W-1:0]    net_value,
    output logic [WEIGHT_W-1:0] weight_units,
    output logic                busy_res,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [1:0]  gain_select_reg;
    logic [7:0]  sample_count_reg;
    logic [24:0] zero_offset_reg;
    logic [31:0] scale_reciprocal_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;

    lcar_cmd_t   cmd;
    lcar_sts_t   sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_select_reg      <= GAIN_SELECT_RST;
            sample_count_reg     <= SAMPLE_COUNT_RST;
            zero_offset_reg      <= ZERO_OFFSET_RST;
            scale_reciprocal_reg <= SCALE_RECIPROCAL_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_GAIN_SELECT:      gain_select_reg      <= pwdata[1:0];
                REG_SAMPLE_COUNT:     sample_count_reg     <= pwdata[7:0];
                REG_ZERO_OFFSET:      zero_offset_reg      <= pwdata[24:0];
                REG_SCALE_RECIPROCAL: scale_reciprocal_reg <= pwdata;
                default:              ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (reg_index)
            REG_GAIN_SELECT:      prdata = {30'd0, gain_select_reg};
            REG_SAMPLE_COUNT:     prdata = {24'd0, sample_count_reg};
            REG_ZERO_OFFSET:      prdata = {{7{zero_offset_reg[24]}}, zero_offset_reg};
            REG_SCALE_RECIPROCAL: prdata = scale_reciprocal_reg;
            default:              prdata = '0;
        endcase
    end

    lcar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lcar_dp #(
        .DATA_BITS       (DATA_BITS),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .dout_level       (dout_level),
        .start_request    (start_request),
        .gain_select      (gain_select_reg),
        .sample_count     (sample_count_reg),
        .zero_offset      (zero_offset_reg),
        .scale_reciprocal (scale_reciprocal_reg),
        .sck_level        (sck_level),
        .measure_done     (measure_done),
        .raw_average      (raw_average),
        .net_value        (net_value),
        .weight_units     (weight_units),
        .busy_res         (busy_res)
    );

endmodule

FILE: tb/sv/tb_load_cell_adc_reader_top.sv
// ----------------------------------------------------------------------------
// tb_load_cell_adc_reader_top
// Self-checking bench for the load cell reader. A queue of tick words feeds a
// valid/ready driver with random gaps, a stalling receiver drains the result
// words, and an in-bench predictor of the serial clock sequencer, averager
// and fixed-point scaler checks every result word field by field. Registers
// are rewritten over the APB port between phases, once all results are in.
// ----------------------------------------------------------------------------
module tb_load_cell_adc_reader_top;
    import lcar_pkg::*;

    localparam int     RANDOM_WORDS = 100;
    localparam int     WEIGHT_SHIFT = RECIP_FRAC_BITS_DEF - 8;
    localparam longint WEIGHT_MAX   = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
    localparam longint WEIGHT_MIN   = -(longint'(1) <<< (WEIGHT_W - 1));
    localparam logic [DATA_BITS_DEF-1:0] SIGN_FLIP = {1'b1, {(DATA_BITS_DEF-1){1'b0}}};

    // Serial clock pulses per conversion, indexed by gain code
    localparam logic [4:0] PULSES_PER_GAIN [4] = '{5'd25, 5'd27, 5'd26, 5'd25};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_SCK_HIGH,
        ST_SCK_LOW
    } reader_phase_t;

    typedef struct packed {
        logic dout;
        logic start;
    } tick_word_t;

    typedef struct packed {
        logic                sck;
        logic                done;
        logic [RAW_W-1:0]    raw;
        logic [NET_W-1:0]    net;
        logic [WEIGHT_W-1:0] weight;
        logic                busy;
    } tick_result_t;

    // DUT signals
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                dout_level = 1'b0;
    logic                start_request = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                sck_level;
    logic                measure_done;
    logic [RAW_W-1:0]    raw_average;
    logic [NET_W-1:0]    net_value;
    logic [WEIGHT_W-1:0] weight_units;
    logic                busy_res;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Register copies
    logic [1:0]         cfg_gain   = GAIN_SELECT_RST;
    logic [7:0]         cfg_count  = SAMPLE_COUNT_RST;
    logic signed [24:0] cfg_offset = ZERO_OFFSET_RST;
    logic signed [31:0] cfg_recip  = SCALE_RECIPROCAL_RST;

    // Sequencer and averager state
    reader_phase_t          rd_phase     = ST_IDLE;
    logic [4:0]             bit_count    = '0;
    logic [DATA_BITS_DEF-1:0] data_shift = '0;
    logic [SUM_W-1:0]       conv_sum     = '0;
    logic [7:0]             conv_count   = '0;
    logic [1:0]             latched_gain = GAIN_A128;
    logic                   discard_next = 1'b0;

    tick_word_t   tick_words[$];
    tick_result_t awaited_results[$];
    int           words_queued   = 0;
    int           mismatch_count = 0;
    int           send_gap       = 0;
    int           stall_left     = 0;
    bit           word_taken     = 1'b0;

    load_cell_adc_reader_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .dout_level    (dout_level),
        .start_request (start_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sck_level     (sck_level),
        .measure_done  (measure_done),
        .raw_average   (raw_average),
        .net_value     (net_value),
        .weight_units  (weight_units),
        .busy_res      (busy_res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the reader by one tick and queue the result word it yields
    function automatic void compute_tick_result(input logic dout, input logic start);
        tick_result_t r;
        logic [1:0]   g;
        logic [31:0]  word_value;
        logic [8:0]   want;
        logic [8:0]   divisor;
        logic [RAW_W-1:0] avg;
        longint       net;
        longint       prod;
        longint       scaled;
        r = '0;
        case (rd_phase)
            ST_IDLE:
            begin
                if (start)
                begin
                    g = (cfg_gain == GAIN_UNUSED) ? GAIN_A128 : cfg_gain;
                    conv_sum = '0;
                    conv_count = '0;
                    // A gain change costs one throwaway conversion
                    if (g != latched_gain)
                    begin
                        latched_gain = g;
                        discard_next = 1'b1;
                    end
                    rd_phase = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!dout)
                begin
                    bit_count = '0;
                    data_shift = '0;
                    rd_phase = ST_SCK_HIGH;
                end
            end
            ST_SCK_HIGH:
            begin
                r.sck = 1'b1;
                rd_phase = ST_SCK_LOW;
            end
            default:
            begin
                if (bit_count < DATA_BITS_DEF)
                    data_shift = {data_shift[DATA_BITS_DEF-2:0], dout};
                bit_count = bit_count + 5'd1;
                if (bit_count >= PULSES_PER_GAIN[latched_gain])
                begin
                    word_value = 32'(data_shift ^ SIGN_FLIP);
                    bit_count = '0;
                    rd_phase = ST_WAIT;
                    if (discard_next)
                        discard_next = 1'b0;
                    else
                    begin
                        want = (cfg_count == 8'd0) ? 9'd1 : {1'b0, cfg_count};
                        conv_sum = conv_sum + word_value;
                        conv_count = conv_count + 8'd1;
                        if (conv_count == 8'd0 || {1'b0, conv_count} >= want)
                        begin
                            divisor = (conv_count == 8'd0) ? 9'd256 : {1'b0, conv_count};
                            avg = RAW_W'(conv_sum / divisor);
                            net = longint'(avg) - longint'(cfg_offset);
                            prod = net * longint'(cfg_recip);
                            // Floor shift, then clamp to the output range
                            scaled = prod >>> WEIGHT_SHIFT;
                            if (scaled > WEIGHT_MAX)
                                scaled = WEIGHT_MAX;
                            if (scaled < WEIGHT_MIN)
                                scaled = WEIGHT_MIN;
                            r.done = 1'b1;
                            r.raw = avg;
                            r.net = net[NET_W-1:0];
                            r.weight = scaled[WEIGHT_W-1:0];
                            rd_phase = ST_IDLE;
                        end
                    end
                end
                else
                    rd_phase = ST_SCK_HIGH;
            end
        endcase
        r.busy = (rd_phase != ST_IDLE);
        awaited_results.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Record each accepted word and predict its result
    always @(posedge clk)
    begin
        word_taken = in_valid && in_ready;
        if (rst_n && word_taken)
            compute_tick_result(dout_level, start_request);
    end

    // Drive tick words; hold valid and payload until taken
    always @(negedge clk)
    begin : drive_ticks
        tick_word_t w;
        if (rst_n && !(in_valid && !word_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (tick_words.size() > 0)
            begin
                w = tick_words.pop_front();
                in_valid <= 1'b1;
                dout_level <= w.dout;
                start_request <= w.start;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        tick_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result word with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                e = awaited_results.pop_front();
                check_field("sck_level", 64'(e.sck), 64'(sck_level));
                check_field("measure_done", 64'(e.done), 64'(measure_done));
                check_field("raw_average", 64'(e.raw), 64'(raw_average));
                check_field("net_value", 64'(e.net), 64'(net_value));
                check_field("weight_units", 64'(e.weight), 64'(weight_units));
                check_field("busy_res", 64'(e.busy), 64'(busy_res));
            end
        end
    end

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_GAIN_SELECT:      cfg_gain = value[1:0];
            REG_SAMPLE_COUNT:     cfg_count = value[7:0];
            REG_ZERO_OFFSET:      cfg_offset = value[24:0];
            REG_SCALE_RECIPROCAL: cfg_recip = value;
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_tick(input logic dout, input logic start);
        tick_words.push_back(tick_word_t'({dout, start}));
        words_queued++;
    endtask

    // Wait until every queued word is sent and every result has come
    task automatic wait_results_drained();
        while (tick_words.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Feed single random ticks until the reader is back in idle
    task automatic settle_to_idle();
        while (rd_phase != ST_IDLE)
        begin
            push_tick(1'($urandom_range(0, 1)), 1'b0);
            wait_results_drained();
        end
    endtask

    function automatic logic [DATA_BITS_DEF-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return SIGN_FLIP;
            1:       return ~SIGN_FLIP;
            2:       return '0;
            3:       return '1;
            default: return DATA_BITS_DEF'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = 32'hFF00_0000;
            1:       v = 32'h00FF_FFFF;
            2:       v = '0;
            default:
            begin
                v = $urandom;
                v = {{7{v[24]}}, v[24:0]};
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_recip();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            3:       v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h0200_0000);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // One conversion: wait on data-out high, drop it, then clock out the bits
    task automatic queue_conversion(input int pulses, input logic [DATA_BITS_DEF-1:0] data);
        int waits;
        waits = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        repeat (waits) push_tick(1'b1, 1'($urandom_range(0, 1)));
        push_tick(1'b0, 1'($urandom_range(0, 1)));
        for (int p = 0; p < pulses; p++)
        begin
            push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            push_tick((p < DATA_BITS_DEF) ? data[DATA_BITS_DEF-1-p] : 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Whole measurements; call only with the reader idle and drained
    task automatic queue_measurements(input int count);
        logic [1:0] g;
        int         pulses;
        int         conversions;
        int         per_measure;
        g = (cfg_gain == GAIN_UNUSED) ? GAIN_A128 : cfg_gain;
        pulses = PULSES_PER_GAIN[g];
        per_measure = (cfg_count == 8'd0) ? 1 : int'(cfg_count);
        conversions = per_measure + ((g != latched_gain) ? 1 : 0);
        repeat (count)
        begin
            repeat ($urandom_range(0, 2)) push_tick(1'($urandom_range(0, 1)), 1'b0);
            push_tick(1'($urandom_range(0, 1)), 1'b1);
            repeat (conversions) queue_conversion(pulses, pick_data());
            conversions = per_measure;
        end
    endtask

    task automatic run_setting(input logic [1:0] g, input logic [7:0] cnt,
                               input logic [31:0] off, input logic [31:0] recip);
        write_reg(REG_GAIN_SELECT, 32'(g));
        write_reg(REG_SAMPLE_COUNT, 32'(cnt));
        write_reg(REG_ZERO_OFFSET, off);
        write_reg(REG_SCALE_RECIPROCAL, recip);
        queue_measurements(1);
        wait_results_drained();
        settle_to_idle();
    endtask

    // Stimulus
    initial
    begin : stimulus
        int random_base;
        int n;
        bit high_bias;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short measurements from here on
        write_reg(REG_SAMPLE_COUNT, 32'd1);

        // Idle ticks, start, start while busy, wait held by data-out high
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        wait_results_drained();
        settle_to_idle();

        // Register extremes, unused gain code and zero count
        run_setting(GAIN_A64, 8'd0, 32'hFF00_0000, 32'h7FFF_FFFF);
        run_setting(GAIN_B32, 8'd1, 32'h00FF_FFFF, 32'h8000_0000);
        run_setting(GAIN_UNUSED, 8'd2, 32'h0, 32'h0);
        run_setting(GAIN_A128, 8'd1, 32'h0000_1234, SCALE_RECIPROCAL_RST);

        // Lower the count mid-measurement; the gain stays latched
        write_reg(REG_GAIN_SELECT, 32'(GAIN_A64));
        write_reg(REG_SAMPLE_COUNT, 32'd255);
        push_tick(1'b0, 1'b1);
        repeat (3) queue_conversion(PULSES_PER_GAIN[GAIN_A64], pick_data());
        wait_results_drained();
        write_reg(REG_SAMPLE_COUNT, 32'd1);
        write_reg(REG_GAIN_SELECT, 32'(GAIN_B32));
        write_reg(REG_ZERO_OFFSET, pick_offset());
        write_reg(REG_SCALE_RECIPROCAL, pick_recip());
        queue_conversion(PULSES_PER_GAIN[GAIN_A64], pick_data());
        wait_results_drained();
        settle_to_idle();

        // Random phases: new settings, then measurements or noise
        random_base = words_queued;
        while (words_queued - random_base < RANDOM_WORDS)
        begin
            wait_results_drained();
            settle_to_idle();
            if ($urandom_range(0, 1))
                write_reg(REG_GAIN_SELECT, $urandom_range(0, 3));
            if ($urandom_range(0, 1))
            begin
                n = $urandom_range(0, 9);
                write_reg(REG_SAMPLE_COUNT, (n == 0) ? 0 : (n < 7) ? 1 : (n < 9) ? 2 : 3);
            end
            if ($urandom_range(0, 1))
                write_reg(REG_ZERO_OFFSET, pick_offset());
            if ($urandom_range(0, 1))
                write_reg(REG_SCALE_RECIPROCAL, pick_recip());
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(10, 60);
                high_bias = 1'($urandom_range(0, 1));
                repeat (n)
                    push_tick(high_bias ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) == 0);
            end
            else
                queue_measurements($urandom_range(1, 2));
        end
        wait_results_drained();
        settle_to_idle();

        // Let the last word clear the pipeline
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb_load_cell_adc_reader_top OK");
        else
            $display("tb_load_cell_adc_reader_top NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("tb_load_cell_adc_reader_top NOT OK");
        $finish;
    end

endmodule
